@@ rtl/ean13me_pkg.sv @@
// ----------------------------------------------------------------------------
// EAN-13 encoder package
// Shared item type, error codes, segment constants and code tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ean13me_pkg;

  // Error codes carried by every result item.
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrCheck = 2'd1;
  localparam logic [1:0] ErrDigit = 2'd2;

  // Segment positions within the symbol.
  localparam logic [3:0] SegStartGuard  = 4'd0;
  localparam logic [3:0] SegCentreGuard = 4'd7;
  localparam logic [3:0] SegEndGuard    = 4'd14;

  // Segment lengths in modules.
  localparam logic [2:0] GuardLen  = 3'd3;
  localparam logic [2:0] CentreLen = 3'd5;
  localparam logic [2:0] DigitLen  = 3'd7;

  // Guard patterns, first module in the most significant used bit.
  localparam logic [6:0] GuardBits  = 7'h05;
  localparam logic [6:0] CentreBits = 7'h0A;

  // Number of digit nibbles in one code.
  localparam int unsigned NumDigits = 13;

  // A code on its way from the check pipeline to the segment emitter.
  typedef struct packed {
    logic [51:0] code;  // thirteen digits, check digit filled in
    logic [3:0]  chk;   // computed check digit
    logic [1:0]  err;   // error code
  } item_t;

  // R code of a digit. The L code is its complement and the G code its
  // mirror image.
  function automatic logic [6:0] r_code(input logic [3:0] digit);
    logic [6:0] res;
    case (digit)
      4'd0:    res = 7'h72;
      4'd1:    res = 7'h66;
      4'd2:    res = 7'h6C;
      4'd3:    res = 7'h42;
      4'd4:    res = 7'h5C;
      4'd5:    res = 7'h4E;
      4'd6:    res = 7'h50;
      4'd7:    res = 7'h44;
      4'd8:    res = 7'h48;
      4'd9:    res = 7'h74;
      default: res = 7'h00;
    endcase
    return res;
  endfunction

  // Parity of the six left digits chosen by the first digit. The left
  // digit at position i uses bit 5-i; a one selects the G code.
  function automatic logic [5:0] parity_pattern(input logic [3:0] digit);
    logic [5:0] res;
    case (digit)
      4'd0:    res = 6'b000000;
      4'd1:    res = 6'b001011;
      4'd2:    res = 6'b001101;
      4'd3:    res = 6'b001110;
      4'd4:    res = 6'b010011;
      4'd5:    res = 6'b011001;
      4'd6:    res = 6'b011100;
      4'd7:    res = 6'b010101;
      4'd8:    res = 6'b010110;
      4'd9:    res = 6'b011010;
      default: res = 6'b000000;
    endcase
    return res;
  endfunction

  // True for a nibble that is not a decimal digit.
  function automatic logic nibble_bad(input logic [3:0] nib);
    return nib[3] & (nib[2] | nib[1]);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ean13me_check_pipe.sv @@
// ----------------------------------------------------------------------------
// EAN-13 check digit pipeline
// Three register stages: digit screening and partial sums, weighted total,
// then modulo-10 reduction, check digit compare and error coding.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13me_check_pipe (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [51:0]         code_bcd_i,
  input  wire logic                has_check_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ean13me_pkg::item_t       out_item_o
);

  // Stage valid bits and the ready chain that lets a stage move on when the
  // stage after it is empty or moving on itself.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage one: screen the nibbles and form the two partial sums.
  logic [51:0] s1_code_q;
  logic        s1_has_check_q;
  logic        s1_bad_q, s1_bad_d;
  logic [6:0]  s1_sum_a_q, s1_sum_a_d;
  logic [6:0]  s1_sum_b_q, s1_sum_b_d;

  always_comb begin
    s1_bad_d   = has_check_i & ean13me_pkg::nibble_bad(code_bcd_i[3:0]);
    s1_sum_a_d = '0;
    s1_sum_b_d = '0;
    for (int i = 0; i < 12; i++) begin
      s1_bad_d = s1_bad_d | ean13me_pkg::nibble_bad(code_bcd_i[4*(12-i) +: 4]);
      if (i % 2 == 0) begin
        s1_sum_a_d = s1_sum_a_d + 7'(code_bcd_i[4*(12-i) +: 4]);
      end else begin
        s1_sum_b_d = s1_sum_b_d + 7'(code_bcd_i[4*(12-i) +: 4]);
      end
    end
  end

  // Stage two: weight the odd positions by three and add.
  logic [51:0] s2_code_q;
  logic        s2_has_check_q;
  logic        s2_bad_q;
  logic [8:0]  s2_total_q, s2_total_d;

  assign s2_total_d = 9'(s1_sum_a_q) + {1'b0, s1_sum_b_q, 1'b0} + 9'(s1_sum_b_q);

  // Stage three: reduce modulo ten by compare and subtract, then code the
  // result of the check.
  logic [8:0]  rem;
  logic [3:0]  chk;
  ean13me_pkg::item_t s3_item_q, s3_item_d;

  always_comb begin
    rem = s2_total_q;
    if (rem >= 9'd320) rem = rem - 9'd320;
    if (rem >= 9'd160) rem = rem - 9'd160;
    if (rem >= 9'd80)  rem = rem - 9'd80;
    if (rem >= 9'd40)  rem = rem - 9'd40;
    if (rem >= 9'd20)  rem = rem - 9'd20;
    if (rem >= 9'd10)  rem = rem - 9'd10;
    chk = (rem == 9'd0) ? 4'd0 : 4'(9'd10 - rem);

    s3_item_d.code = s2_code_q;
    s3_item_d.chk  = chk;
    s3_item_d.err  = ean13me_pkg::ErrNone;
    if (s2_bad_q) begin
      s3_item_d.chk = 4'd0;
      s3_item_d.err = ean13me_pkg::ErrDigit;
    end else if (s2_has_check_q) begin
      if (s2_code_q[3:0] != chk) begin
        s3_item_d.err = ean13me_pkg::ErrCheck;
      end
    end else begin
      s3_item_d.code[3:0] = chk;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_code_q      <= code_bcd_i;
      s1_has_check_q <= has_check_i;
      s1_bad_q       <= s1_bad_d;
      s1_sum_a_q     <= s1_sum_a_d;
      s1_sum_b_q     <= s1_sum_b_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_code_q      <= s1_code_q;
      s2_has_check_q <= s1_has_check_q;
      s2_bad_q       <= s1_bad_q;
      s2_total_q     <= s2_total_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_item_q <= s3_item_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_item_o  = s3_item_q;

endmodule

`default_nettype wire

@@ rtl/ean13me_segment_emitter.sv @@
// ----------------------------------------------------------------------------
// EAN-13 segment emitter
// Holds one checked code and steps through its fifteen segments, or a single
// error item, one per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13me_segment_emitter (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ean13me_pkg::item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [6:0]               segment_bits_o,
  output logic [2:0]               segment_length_o,
  output logic [3:0]               segment_index_o,
  output logic [3:0]               check_digit_o,
  output logic [1:0]               error_code_o,
  output logic                     last_segment_o
);

  // Code being emitted and its segment counter.
  logic               busy_q, busy_d;
  logic [3:0]         cnt_q, cnt_d;
  ean13me_pkg::item_t item_q;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [6:0]         bits_q, bits_d;
  logic [2:0]         len_q, len_d;
  logic [3:0]         idx_q, idx_d;
  logic [3:0]         chk_q;
  logic [1:0]         err_q;
  logic               last_q, last_d;

  logic               out_adv;
  logic               is_last;
  logic               load;

  // Digit selection for the segment under the counter.
  logic [3:0]         dig [ean13me_pkg::NumDigits];
  logic [3:0]         dig_idx;
  logic [2:0]         par_idx;
  logic [5:0]         parity;
  logic [6:0]         rc;
  logic [6:0]         rc_mirror;

  always_comb begin
    for (int j = 0; j < ean13me_pkg::NumDigits; j++) begin
      dig[j] = item_q.code[4*(12-j) +: 4];
    end
  end

  assign dig_idx = (cnt_q < ean13me_pkg::SegCentreGuard) ? cnt_q : (cnt_q - 4'd1);
  assign par_idx = 3'(4'd6 - cnt_q);
  assign parity  = ean13me_pkg::parity_pattern(dig[0]);
  assign rc      = ean13me_pkg::r_code(dig[dig_idx]);

  always_comb begin
    for (int b = 0; b < 7; b++) begin
      rc_mirror[b] = rc[6-b];
    end
  end

  // Segment contents for the counter value.
  always_comb begin
    bits_d = '0;
    len_d  = '0;
    idx_d  = cnt_q;
    last_d = 1'b0;
    if (item_q.err != ean13me_pkg::ErrNone) begin
      idx_d  = '0;
      last_d = 1'b1;
    end else begin
      case (cnt_q)
        ean13me_pkg::SegStartGuard: begin
          bits_d = ean13me_pkg::GuardBits;
          len_d  = ean13me_pkg::GuardLen;
        end
        ean13me_pkg::SegCentreGuard: begin
          bits_d = ean13me_pkg::CentreBits;
          len_d  = ean13me_pkg::CentreLen;
        end
        ean13me_pkg::SegEndGuard: begin
          bits_d = ean13me_pkg::GuardBits;
          len_d  = ean13me_pkg::GuardLen;
          last_d = 1'b1;
        end
        default: begin
          len_d = ean13me_pkg::DigitLen;
          if (cnt_q < ean13me_pkg::SegCentreGuard) begin
            bits_d = parity[par_idx] ? rc_mirror : ~rc;
          end else begin
            bits_d = rc;
          end
        end
      endcase
    end
  end

  // Handshake and counter control.
  assign out_adv    = !out_valid_q || out_ready_i;
  assign is_last    = last_d;
  assign in_ready_o = !busy_q || (out_adv && is_last);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        cnt_d = cnt_q + 4'd1;
        if (is_last) busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = ean13me_pkg::SegStartGuard;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= ean13me_pkg::SegStartGuard;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
    if (out_adv && busy_q) begin
      bits_q <= bits_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
      chk_q  <= item_q.chk;
      err_q  <= item_q.err;
      last_q <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign segment_bits_o   = bits_q;
  assign segment_length_o = len_q;
  assign segment_index_o  = idx_q;
  assign check_digit_o    = chk_q;
  assign error_code_o     = err_q;
  assign last_segment_o   = last_q;

endmodule

`default_nettype wire

@@ rtl/ean13_module_pattern_encoder_core.sv @@
// Flow: after the edge that accepts a code, it passes two more check stages,
// the emitter load and the output stage before its first segment appears.
// Throughput: one segment per cycle unless the output stalls, set by the
// segment emitter's single output port; a code in error gives one item.
// Reset: asynchronous, active low; clears all valid bits and the emitter.
// ----------------------------------------------------------------------------
// EAN-13 module pattern encoder
// Checks an EAN-13 code; emits its bar pattern as fifteen segments or an error.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13_module_pattern_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [51:0] code_bcd_i,
  input  wire logic        has_check_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       segment_bits_o,
  output logic [2:0]       segment_length_o,
  output logic [3:0]       segment_index_o,
  output logic [3:0]       check_digit_o,
  output logic [1:0]       error_code_o,
  output logic             last_segment_o
);

  // Checked item passing from the pipeline to the emitter.
  logic               chk_valid;
  logic               chk_ready;
  ean13me_pkg::item_t chk_item;

  // Check digit computation and validation.
  ean13me_check_pipe u_check_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_bcd_i  (code_bcd_i),
    .has_check_i (has_check_i),
    .out_valid_o (chk_valid),
    .out_ready_i (chk_ready),
    .out_item_o  (chk_item)
  );

  // Segment generation.
  ean13me_segment_emitter u_segment_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (chk_valid),
    .in_ready_o       (chk_ready),
    .in_item_i        (chk_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .segment_bits_o   (segment_bits_o),
    .segment_length_o (segment_length_o),
    .segment_index_o  (segment_index_o),
    .check_digit_o    (check_digit_o),
    .error_code_o     (error_code_o),
    .last_segment_o   (last_segment_o)
  );

endmodule

`default_nettype wire

@@ rtl/ean13me_checker.sv @@
// ----------------------------------------------------------------------------
// EAN-13 encoder port checker
// Watches the top level's ports for ordering and coding of result items.
// ----------------------------------------------------------------------------
`default_nettype none

module ean13me_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [51:0] code_bcd_i,
  input wire logic        has_check_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [6:0]  segment_bits_o,
  input wire logic [2:0]  segment_length_o,
  input wire logic [3:0]  segment_index_o,
  input wire logic [3:0]  check_digit_o,
  input wire logic [1:0]  error_code_o,
  input wire logic        last_segment_o
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(segment_bits_o)
      && $stable(segment_index_o) && $stable(error_code_o))
    else $error("result item changed while stalled");

  // An error item is a single, empty final item.
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ean13me_pkg::ErrNone |->
      last_segment_o && segment_length_o == 3'd0 && segment_index_o == 4'd0)
    else $error("error item is not a single empty item");

  // On a good code only the end guard closes the symbol.
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ean13me_pkg::ErrNone |->
      (segment_index_o == ean13me_pkg::SegEndGuard) == last_segment_o)
    else $error("last segment flag out of place");

  // Segments of one code follow back to back with the same check digit.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_segment_o |=>
      out_valid_o && segment_index_o == $past(segment_index_o) + 4'd1
      && $stable(check_digit_o))
    else $error("segment sequence broken");

  // The check digit is always decimal.
  a_chk_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> check_digit_o <= 4'd9)
    else $error("check digit above nine");

endmodule

bind ean13_module_pattern_encoder_core ean13me_checker u_checker (.*);

`default_nettype wire

@@ dv/tb_ean13_module_pattern_encoder_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EAN-13 module pattern encoder testbench
// Offers EAN-13 codes with and without a supplied check digit, predicts the
// fifteen bar segments or the single error item for each accepted code, and
// compares every result item field by field. Both sides idle at random; one
// phase holds the output off long enough to fill the block.
// ----------------------------------------------------------------------------

module tb_ean13_module_pattern_encoder_core;

  // One predicted result item.
  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] len;
    logic [3:0] idx;
    logic [3:0] chk;
    logic [1:0] err;
    logic       last;
  } segment_t;

  // Digit codes, first module in the most significant used bit.
  localparam logic [6:0] LCodes [10] = '{7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
                                         7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};
  localparam logic [6:0] GCodes [10] = '{7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D,
                                         7'h39, 7'h05, 7'h11, 7'h09, 7'h17};
  localparam logic [6:0] RCodes [10] = '{7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C,
                                         7'h4E, 7'h50, 7'h44, 7'h48, 7'h74};
  // G selection of the six left digits per first digit; bit 5 is the first.
  localparam logic [5:0] LeftGMask [10] = '{6'b000000, 6'b001011, 6'b001101,
                                            6'b001110, 6'b010011, 6'b011001,
                                            6'b011100, 6'b010101, 6'b010110,
                                            6'b011010};

  // Longest correct stretch without any transfer is the output hold-off.
  localparam int HoldOffCycles = 200;
  localparam int StallLimit    = 1000;
  localparam int DrainCycles   = 20;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [51:0] code_bcd_i  = '0;
  logic        has_check_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  segment_bits_o;
  logic [2:0]  segment_length_o;
  logic [3:0]  segment_index_o;
  logic [3:0]  check_digit_o;
  logic [1:0]  error_code_o;
  logic        last_segment_o;

  segment_t expected_segments [$];
  int       mismatch_count   = 0;
  int       idle_cycles      = 0;
  int       sink_hold_cycles = 0;
  logic     src_idle_en      = 1'b1;
  logic     sink_idle_en     = 1'b1;

  ean13_module_pattern_encoder_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .code_bcd_i       (code_bcd_i),
    .has_check_i      (has_check_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .segment_bits_o   (segment_bits_o),
    .segment_length_o (segment_length_o),
    .segment_index_o  (segment_index_o),
    .check_digit_o    (check_digit_o),
    .error_code_o     (error_code_o),
    .last_segment_o   (last_segment_o)
  );

  always #5 clk_i = ~clk_i;

  // Weighted (1,3) modulo-10 check digit over the first twelve nibbles.
  function automatic logic [3:0] weighted_check_digit(input logic [51:0] code);
    int sum;
    sum = 0;
    for (int i = 0; i < 12; i++) begin
      sum += ((i % 2 == 1) ? 3 : 1) * int'(code[51-4*i -: 4]);
    end
    return 4'((10 - sum % 10) % 10);
  endfunction

  // Queues the result items that one accepted code must produce.
  function automatic void predict_symbol(input logic [51:0] code, input logic hc);
    logic [3:0] dig [13];
    logic [3:0] chk;
    logic       bad;
    segment_t   seg;
    bad = 1'b0;
    seg = '0;
    for (int i = 0; i < 13; i++) begin
      dig[i] = code[51-4*i -: 4];
    end
    for (int i = 0; i < 12; i++) begin
      if (dig[i] > 4'd9) bad = 1'b1;
    end
    // The lowest nibble is only examined when it is to be verified.
    if (hc && dig[12] > 4'd9) bad = 1'b1;
    if (bad) begin
      seg.err  = ean13me_pkg::ErrDigit;
      seg.last = 1'b1;
      expected_segments.push_back(seg);
      return;
    end
    chk = weighted_check_digit(code);
    if (hc && dig[12] != chk) begin
      seg.err  = ean13me_pkg::ErrCheck;
      seg.chk  = chk;
      seg.last = 1'b1;
      expected_segments.push_back(seg);
      return;
    end
    dig[12] = chk;
    seg.chk = chk;
    seg.err = ean13me_pkg::ErrNone;
    // Start guard, six left digits, centre guard, six right digits, end guard.
    for (int k = 0; k < 15; k++) begin
      seg.idx  = 4'(k);
      seg.last = (4'(k) == ean13me_pkg::SegEndGuard);
      if (4'(k) == ean13me_pkg::SegStartGuard || 4'(k) == ean13me_pkg::SegEndGuard) begin
        seg.bits = ean13me_pkg::GuardBits;
        seg.len  = ean13me_pkg::GuardLen;
      end else if (4'(k) == ean13me_pkg::SegCentreGuard) begin
        seg.bits = ean13me_pkg::CentreBits;
        seg.len  = ean13me_pkg::CentreLen;
      end else if (k < 7) begin
        seg.bits = LeftGMask[dig[0]][6-k] ? GCodes[dig[k]] : LCodes[dig[k]];
        seg.len  = ean13me_pkg::DigitLen;
      end else begin
        seg.bits = RCodes[dig[k-1]];
        seg.len  = ean13me_pkg::DigitLen;
      end
      expected_segments.push_back(seg);
    end
  endfunction

  // Twelve random decimal digits with a correct check digit in the lowest nibble.
  function automatic logic [51:0] random_digits(input int first);
    logic [51:0] code;
    code = '0;
    for (int i = 0; i < 12; i++) begin
      code[51-4*i -: 4] = 4'($urandom_range(9));
    end
    if (first >= 0) code[51:48] = 4'(first);
    code[3:0] = weighted_check_digit(code);
    return code;
  endfunction

  // Offers one code after a random gap and returns at the edge that takes it.
  task automatic offer_code(input logic [51:0] code, input logic hc);
    int gap;
    gap = src_idle_en ? $urandom_range(14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_bcd_i  <= code;
    has_check_i <= hc;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering and waits until every predicted item has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_segments.size() != 0) @(posedge clk_i);
  endtask

  // Zeros, every first digit, ignored nibble, wrong check and bad nibbles.
  task automatic test_directed();
    logic [51:0] code;
    offer_code('0, 1'b0);
    offer_code('0, 1'b1);
    for (int d = 0; d < 10; d++) begin
      offer_code(random_digits(d), 1'b1);
    end
    offer_code({48'h999999999999, 4'hF}, 1'b0);
    code = random_digits(-1);
    code[3:0] = 4'((int'(code[3:0]) + 5) % 10);
    offer_code(code, 1'b1);
    offer_code({4'hF, 48'h0}, 1'b0);
    offer_code(52'h123456A789012, 1'b0);
    code = random_digits(-1);
    code[3:0] = 4'hB;
    offer_code(code, 1'b1);
    offer_code(code, 1'b0);
    // A bad nibble takes priority over a wrong check digit.
    code = random_digits(-1);
    code[27:24] = 4'hC;
    code[3:0] = 4'((int'(code[3:0]) + 3) % 10);
    offer_code(code, 1'b1);
    offer_code('1, 1'b1);
    wait_for_drain();
  endtask

  // Mostly well-formed codes, with wrong check digits, bad nibbles and noise.
  task automatic test_random();
    logic [51:0] code;
    logic        hc;
    int          sel;
    int          pos;
    for (int n = 0; n < 120; n++) begin
      sel = $urandom_range(99);
      hc  = 1'($urandom_range(1));
      code = random_digits(-1);
      if (sel < 60) begin
        if (!hc) code[3:0] = 4'($urandom_range(15));
      end else if (sel < 75) begin
        hc = 1'b1;
        code[3:0] = 4'((int'(code[3:0]) + 1 + $urandom_range(8)) % 10);
      end else if (sel < 88) begin
        pos = $urandom_range(12);
        code[51-4*pos -: 4] = 4'($urandom_range(15, 10));
      end else begin
        code = 52'({$urandom(), $urandom()});
      end
      offer_code(code, hc);
    end
    wait_for_drain();
  endtask

  // Output held off while codes keep coming, so the input must stall.
  task automatic test_backpressure();
    src_idle_en      = 1'b0;
    sink_hold_cycles = HoldOffCycles;
    for (int n = 0; n < 20; n++) begin
      offer_code(random_digits(-1), 1'($urandom_range(1)));
    end
    wait_for_drain();
    src_idle_en = 1'b1;
  endtask

  // Back-to-back codes with the output always ready.
  task automatic test_no_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int n = 0; n < 15; n++) begin
      offer_code(random_digits(-1), 1'($urandom_range(1)));
    end
    wait_for_drain();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Output ready: a random stall before each item, or a requested hold-off.
  initial begin : sink_driver
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle_en ? $urandom_range(14) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Predict on every accepted code.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) predict_symbol(code_bcd_i, has_check_i);
  end

  // Compare every accepted result item with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_segments.size() == 0) begin
        $error("result item with no prediction waiting");
        mismatch_count++;
      end else begin
        want = expected_segments.pop_front();
        if (segment_bits_o !== want.bits) begin
          $error("segment_bits: expected %0h, got %0h", want.bits, segment_bits_o);
          mismatch_count++;
        end
        if (segment_length_o !== want.len) begin
          $error("segment_length: expected %0d, got %0d", want.len, segment_length_o);
          mismatch_count++;
        end
        if (segment_index_o !== want.idx) begin
          $error("segment_index: expected %0d, got %0d", want.idx, segment_index_o);
          mismatch_count++;
        end
        if (check_digit_o !== want.chk) begin
          $error("check_digit: expected %0d, got %0d", want.chk, check_digit_o);
          mismatch_count++;
        end
        if (error_code_o !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, error_code_o);
          mismatch_count++;
        end
        if (last_segment_o !== want.last) begin
          $error("last_segment: expected %0b, got %0b", want.last, last_segment_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Reset, run the tests in turn, then report.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_segments.size() != 0) begin
      $error("%0d predicted items never came out", expected_segments.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ean13me_pkg.sv
rtl/ean13me_check_pipe.sv
rtl/ean13me_segment_emitter.sv
rtl/ean13_module_pattern_encoder_core.sv
rtl/ean13me_checker.sv
dv/tb_ean13_module_pattern_encoder_core.sv
